@@ rtl/elc_pkg.sv @@
// Shared types and constants for the expiring LRU associative cache.
// Used by the scan unit and the top level; depends on nothing else.
package elc_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam int KEY_W  = 64;
	localparam int VAL_W  = 64;
	localparam int TIME_W = 63;
	localparam int SLOT_W = 6;
	localparam int OP_W   = 2;

	// Evictions of entries touched within the last 3600 s are flagged.
	localparam logic [TIME_W:0] RECENT_US = 64'd3600 * 64'd1000000;

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 2'd0,
		OP_STORE  = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	// One table slot as kept in the entry memory.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [TIME_W-1:0] expire;
		logic [TIME_W-1:0] access;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Request fields, last field in the lowest bits.
	typedef struct packed {
		logic [TIME_W-1:0] now_time;
		logic [TIME_W-1:0] expire_time;
		logic [VAL_W-1:0]  value_in;
		logic [KEY_W-1:0]  key_tag;
	} req_t;

	localparam int REQ_W     = $bits(req_t);
	localparam int IN_DATA_W = ((REQ_W + 7) / 8) * 8;

	// Result fields, last field in the lowest bits.
	typedef struct packed {
		logic              dropped_recent;
		logic [SLOT_W-1:0] slot;
		logic [VAL_W-1:0]  value_out;
		logic              found;
	} resp_t;

	localparam int RESP_W     = $bits(resp_t);
	localparam int OUT_DATA_W = ((RESP_W + 7) / 8) * 8;

	// Control from the sequencer to the scan unit.
	typedef struct packed {
		logic             start;
		logic             cmp;
		logic [IDX_W-1:0] idx;
		logic             ent_valid;
	} scan_ctl_t;

	// What one pass over the table found.
	typedef struct packed {
		logic              match;
		logic [IDX_W-1:0]  match_idx;
		logic [VAL_W-1:0]  match_value;
		logic [TIME_W-1:0] match_expire;
		logic              free;
		logic [IDX_W-1:0]  free_idx;
		logic [IDX_W-1:0]  lru_idx;
		logic [TIME_W-1:0] lru_access;
	} scan_res_t;

endpackage

@@ rtl/expiring_lru_assoc_cache_top.sv @@
// Expiring LRU associative cache, top level. Depends on elc_pkg, elc_ram, elc_scan.
// Each request is scanned one slot at a time: one read of the entry memory per slot,
// a compare of each registered read against the request, then the table update and
// the load of the result register in the finish state.
// A new request is taken only in the idle state, so not before the last result is loaded;
// a result left waiting holds the finish state.
// Reset: valid bits clear at once, so the table is empty with no clearing pass.
module expiring_lru_assoc_cache_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata, lowest bit up: key_tag, value_in, expire_time, now_time, zero pad
	input  logic [elc_pkg::IN_DATA_W-1:0]    s_tdata,
	// s_tuser: opcode
	input  logic [elc_pkg::OP_W-1:0]         s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata, lowest bit up: found, value_out, slot, dropped_recent
	output logic [elc_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import elc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t            state_q;
	logic [OP_W-1:0]   op_q;
	req_t              req_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              cmp_vld_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic [ENTRIES-1:0] valid_q;
	logic              out_valid_q;
	resp_t             resp_q;

	req_t       req_in;
	logic       rd_en;
	entry_t     rd_entry;
	logic [ENTRY_W-1:0] rd_data;
	logic       wr_en;
	logic [IDX_W-1:0] wr_idx;
	entry_t     wr_entry;
	scan_ctl_t  scan_ctl;
	scan_res_t  scan_res;
	logic       finish_go;
	logic       scan_done;
	logic       lru_recent;
	logic       lookup_live;
	resp_t      resp_d;
	logic       set_valid;
	logic       clr_valid;

	assign req_in    = req_t'(s_tdata[REQ_W-1:0]);
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = OUT_DATA_W'(resp_q);

	assign rd_en     = (state_q == S_SCAN) && (cnt_q < CNT_W'(ENTRIES));
	assign scan_done = cmp_vld_s1 && (cmp_idx_s1 == IDX_W'(ENTRIES - 1));
	assign finish_go = (state_q == S_FINISH) && (!out_valid_q || m_tready);
	assign rd_entry  = entry_t'(rd_data);

	always_comb begin
		scan_ctl.start     = s_tvalid && s_tready;
		scan_ctl.cmp       = cmp_vld_s1;
		scan_ctl.idx       = cmp_idx_s1;
		scan_ctl.ent_valid = valid_q[cmp_idx_s1];
	end

	elc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (ENTRY_W'(wr_entry)),
		.re    (rd_en),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	elc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.ent    (rd_entry),
		.key    (req_q.key_tag),
		.now    (req_q.now_time),
		.res    (scan_res)
	);

	// An access time later than now counts as a negative age, so it is recent too.
	assign lru_recent  = ({1'b0, scan_res.lru_access} + RECENT_US) > {1'b0, req_q.now_time};
	assign lookup_live = scan_res.match_expire > req_q.now_time;

	// Table update and result for the request, applied in the finish cycle.
	always_comb begin
		resp_d    = '0;
		wr_en     = 1'b0;
		wr_idx    = scan_res.match_idx;
		wr_entry.key    = req_q.key_tag;
		wr_entry.value  = req_q.value_in;
		wr_entry.expire = req_q.expire_time;
		wr_entry.access = req_q.now_time;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		case (op_q)
			OP_LOOKUP: begin
				if (scan_res.match) begin
					resp_d.slot = SLOT_W'(scan_res.match_idx);
					if (lookup_live) begin
						resp_d.found     = 1'b1;
						resp_d.value_out = scan_res.match_value;
						wr_en            = 1'b1;
						wr_entry.value   = scan_res.match_value;
						wr_entry.expire  = scan_res.match_expire;
					end else begin
						clr_valid = 1'b1;
					end
				end
			end
			OP_STORE: begin
				wr_en     = 1'b1;
				set_valid = 1'b1;
				if (scan_res.match) begin
					wr_idx       = scan_res.match_idx;
					resp_d.found = 1'b1;
				end else if (scan_res.free) begin
					wr_idx = scan_res.free_idx;
				end else begin
					wr_idx                = scan_res.lru_idx;
					resp_d.dropped_recent = lru_recent;
				end
				resp_d.slot = SLOT_W'(wr_idx);
			end
			OP_DELETE: begin
				if (scan_res.match) begin
					clr_valid    = 1'b1;
					resp_d.found = 1'b1;
					resp_d.slot  = SLOT_W'(scan_res.match_idx);
				end
			end
			default: begin
				resp_d = '0;
			end
		endcase
		if (!finish_go) begin
			wr_en     = 1'b0;
			set_valid = 1'b0;
			clr_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			cmp_vld_s1  <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
			if (rd_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (set_valid) begin
				valid_q[wr_idx] <= 1'b1;
			end else if (clr_valid) begin
				valid_q[scan_res.match_idx] <= 1'b0;
			end
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (finish_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cmp_idx_s1 <= cnt_q[IDX_W-1:0];
		end
		if (s_tvalid && s_tready) begin
			op_q  <= s_tuser;
			req_q <= req_in;
		end
		if (finish_go) begin
			resp_q <= resp_d;
		end
	end

endmodule

@@ rtl/elc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module elc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/elc_scan.sv @@
// Scan unit: compares one table entry per cycle against the request and keeps
// the first match, the first free or expired slot and the least recently used
// slot. Depends on elc_pkg.
module elc_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  elc_pkg::scan_ctl_t          ctl,
	input  elc_pkg::entry_t             ent,
	input  logic [elc_pkg::KEY_W-1:0]   key,
	input  logic [elc_pkg::TIME_W-1:0]  now,
	output elc_pkg::scan_res_t          res
);
	import elc_pkg::*;

	logic              match_q;
	logic [IDX_W-1:0]  match_idx_q;
	logic [VAL_W-1:0]  match_value_q;
	logic [TIME_W-1:0] match_expire_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              has_lru_q;
	logic [IDX_W-1:0]  lru_idx_q;
	logic [TIME_W-1:0] lru_access_q;

	logic hit;
	logic expired;
	logic older;

	assign hit     = ctl.ent_valid && (ent.key == key);
	assign expired = ent.expire <= now;
	assign older   = !has_lru_q || (ent.access < lru_access_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q   <= 1'b0;
			free_q    <= 1'b0;
			has_lru_q <= 1'b0;
		end else if (ctl.start) begin
			match_q   <= 1'b0;
			free_q    <= 1'b0;
			has_lru_q <= 1'b0;
		end else if (ctl.cmp && !match_q) begin
			// Once a match is seen the rest of the table is ignored.
			if (hit) begin
				match_q        <= 1'b1;
				match_idx_q    <= ctl.idx;
				match_value_q  <= ent.value;
				match_expire_q <= ent.expire;
			end else if (!ctl.ent_valid || expired) begin
				if (!free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= ctl.idx;
				end
			end else if (older) begin
				has_lru_q    <= 1'b1;
				lru_idx_q    <= ctl.idx;
				lru_access_q <= ent.access;
			end
		end
	end

	always_comb begin
		res.match        = match_q;
		res.match_idx    = match_idx_q;
		res.match_value  = match_value_q;
		res.match_expire = match_expire_q;
		res.free         = free_q;
		res.free_idx     = free_idx_q;
		res.lru_idx      = lru_idx_q;
		res.lru_access   = lru_access_q;
	end

endmodule
